// ===== design/apls_pkg.sv =====
package apls_pkg;

  localparam int unsigned WordsPerSector           = 256;
  localparam int unsigned SelectStatusReadsDefault = 5;
  localparam int unsigned QueueDepth               = 2;

  localparam logic [7:0]  LastWordIndex = 8'(WordsPerSector - 1);
  localparam logic [15:0] BasePortReset = 16'h01F0;

  localparam logic [2:0] OFS_DATA  = 3'd0;
  localparam logic [2:0] OFS_COUNT = 3'd2;
  localparam logic [2:0] OFS_LBA0  = 3'd3;
  localparam logic [2:0] OFS_LBA1  = 3'd4;
  localparam logic [2:0] OFS_LBA2  = 3'd5;
  localparam logic [2:0] OFS_DRIVE = 3'd6;
  localparam logic [2:0] OFS_CMD   = 3'd7;

  localparam logic [7:0] STATUS_ERR_MASK = 8'h21;
  localparam logic [7:0] STATUS_RDY_MASK = 8'h88;
  localparam logic [7:0] STATUS_RDY_VAL  = 8'h08;
  localparam logic [7:0] DEV_SEL_LBA     = 8'h40;
  localparam logic [7:0] DEV_SEL_SLAVE   = 8'h10;
  localparam logic [7:0] CMD_READ_EXT    = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT   = 8'h34;
  localparam logic [7:0] CMD_FLUSH_CACHE = 8'hE7;

  localparam logic [3:0] TaskLastStep = 4'd9;

  typedef enum logic [1:0] {
    FUNC_REQ     = 2'd0,
    FUNC_RD_ANS  = 2'd1,
    FUNC_WR_WORD = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    K_BUS_WR = 3'd0,
    K_BUS_RD = 3'd1,
    K_HOST   = 3'd2,
    K_DONE   = 3'd3,
    K_ERR    = 3'd4,
    K_NEED   = 3'd5
  } kind_e;

  typedef enum logic {
    REG_IO_BASE      = 1'b0,
    REG_SLAVE_SELECT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    JOB_ERR    = 3'd0,
    JOB_SELECT = 3'd1,
    JOB_POLL   = 3'd2,
    JOB_TASK   = 3'd3,
    JOB_NEED   = 3'd4,
    JOB_RDDATA = 3'd5,
    JOB_HOST   = 3'd6,
    JOB_WDATA  = 3'd7
  } job_op_e;

  typedef enum logic [2:0] {
    TAIL_RDDATA = 3'd0,
    TAIL_NEED   = 3'd1,
    TAIL_POLL   = 3'd2,
    TAIL_DONE   = 3'd3,
    TAIL_FLUSH  = 3'd4
  } tail_e;

  typedef struct packed {
    job_op_e     op;
    tail_e       tail;
    logic [15:0] word;
    logic [47:0] lba;
    logic [15:0] count;
    logic        op_write;
  } job_t;

  typedef struct packed {
    logic [15:0] io_base;
    logic        slave_select;
  } cfg_t;

endpackage

// ===== design/apls_if.sv =====
interface apls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        is_write;
  logic [47:0] lba;
  logic [15:0] sector_count;
  logic [15:0] bus_read_data;
  logic [15:0] write_word;

  modport source (
    output valid, func, is_write, lba, sector_count, bus_read_data, write_word,
    input  ready
  );
  modport sink (
    input  valid, func, is_write, lba, sector_count, bus_read_data, write_word,
    output ready
  );
endinterface

interface apls_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] port;
  logic [15:0] bus_data;
  logic [15:0] host_word;
  logic        last;

  modport source (
    output valid, kind, port, bus_data, host_word, last,
    input  ready
  );
  modport sink (
    input  valid, kind, port, bus_data, host_word, last,
    output ready
  );
endinterface

// ===== design/apls_front.sv =====
module apls_front
  import apls_pkg::*;
#(
  parameter int unsigned SelectStatusReads = SelectStatusReadsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_i,
  apls_in_if.sink      in_i,
  output job_t         job_o,
  output logic         job_valid_o,
  input  logic         job_ready_i
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_DISCARD = 5'b00010,
    PH_POLL    = 5'b00100,
    PH_RDATA   = 5'b01000,
    PH_WDATA   = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        drive_sel_q, drive_sel_d;
  logic [2:0]  discard_q, discard_d;
  logic [15:0] sectors_q, sectors_d;
  logic [7:0]  word_idx_q, word_idx_d;
  logic        op_write_q, op_write_d;
  logic [47:0] lba_q, lba_d;
  logic [15:0] count_q, count_d;

  logic        xfer;
  logic [7:0]  status;
  logic [15:0] sectors_dec;
  logic [2:0]  discard_dec;

  assign in_i.ready  = job_ready_i;
  assign xfer        = in_i.valid && job_ready_i;
  assign status      = in_i.bus_read_data[7:0];
  assign sectors_dec = sectors_q - 16'd1;
  assign discard_dec = discard_q - 3'd1;

  always_comb begin
    phase_d     = phase_q;
    drive_sel_d = drive_sel_q;
    discard_d   = discard_q;
    sectors_d   = sectors_q;
    word_idx_d  = word_idx_q;
    op_write_d  = op_write_q;
    lba_d       = lba_q;
    count_d     = count_q;
    job_valid_o = 1'b0;
    job_o       = '{op: JOB_ERR, tail: TAIL_DONE, word: in_i.bus_read_data,
                    lba: lba_q, count: count_q, op_write: op_write_q};
    if (xfer) begin
      unique case (func_e'(in_i.func))
        FUNC_REQ: begin
          job_valid_o = 1'b1;
          if (phase_q == PH_IDLE && in_i.sector_count != 16'd0) begin
            op_write_d     = in_i.is_write;
            lba_d          = in_i.lba;
            count_d        = in_i.sector_count;
            sectors_d      = in_i.sector_count;
            word_idx_d     = 8'd0;
            job_o.lba      = in_i.lba;
            job_o.count    = in_i.sector_count;
            job_o.op_write = in_i.is_write;
            if (!drive_sel_q) begin
              job_o.op  = JOB_SELECT;
              discard_d = 3'(SelectStatusReads);
              phase_d   = PH_DISCARD;
            end else begin
              job_o.op = JOB_TASK;
              phase_d  = PH_POLL;
            end
          end
        end
        FUNC_RD_ANS: begin
          unique case (phase_q)
            PH_DISCARD: begin
              job_valid_o = 1'b1;
              discard_d   = discard_dec;
              if (discard_dec != 3'd0) begin
                job_o.op = JOB_POLL;
              end else begin
                drive_sel_d = 1'b1;
                job_o.op    = JOB_TASK;
                phase_d     = PH_POLL;
              end
            end
            PH_POLL: begin
              job_valid_o = 1'b1;
              if ((status & STATUS_ERR_MASK) != 8'h00) begin
                job_o.op   = JOB_ERR;
                phase_d    = PH_IDLE;
                sectors_d  = 16'd0;
                word_idx_d = 8'd0;
              end else if ((status & STATUS_RDY_MASK) != STATUS_RDY_VAL) begin
                job_o.op = JOB_POLL;
              end else begin
                word_idx_d = 8'd0;
                if (op_write_q) begin
                  job_o.op = JOB_NEED;
                  phase_d  = PH_WDATA;
                end else begin
                  job_o.op = JOB_RDDATA;
                  phase_d  = PH_RDATA;
                end
              end
            end
            PH_RDATA: begin
              job_valid_o = 1'b1;
              job_o.op    = JOB_HOST;
              if (word_idx_q == LastWordIndex) begin
                word_idx_d = 8'd0;
                sectors_d  = sectors_dec;
                if (sectors_dec != 16'd0) begin
                  job_o.tail = TAIL_POLL;
                  phase_d    = PH_POLL;
                end else begin
                  job_o.tail = TAIL_DONE;
                  phase_d    = PH_IDLE;
                end
              end else begin
                word_idx_d = word_idx_q + 8'd1;
                job_o.tail = TAIL_RDDATA;
              end
            end
            PH_IDLE, PH_WDATA: begin
            end
          endcase
        end
        FUNC_WR_WORD: begin
          if (phase_q == PH_WDATA) begin
            job_valid_o = 1'b1;
            job_o.op    = JOB_WDATA;
            job_o.word  = in_i.write_word;
            if (word_idx_q == LastWordIndex) begin
              word_idx_d = 8'd0;
              sectors_d  = sectors_dec;
              if (sectors_dec != 16'd0) begin
                job_o.tail = TAIL_POLL;
                phase_d    = PH_POLL;
              end else begin
                job_o.tail = TAIL_FLUSH;
                phase_d    = PH_IDLE;
              end
            end else begin
              word_idx_d = word_idx_q + 8'd1;
              job_o.tail = TAIL_NEED;
            end
          end
        end
        FUNC_NONE: begin
        end
      endcase
    end
    if (cfg_wr_i) begin
      drive_sel_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      drive_sel_q <= 1'b0;
      discard_q   <= 3'd0;
      sectors_q   <= 16'd0;
      word_idx_q  <= 8'd0;
      op_write_q  <= 1'b0;
      lba_q       <= 48'd0;
      count_q     <= 16'd0;
    end else begin
      phase_q     <= phase_d;
      drive_sel_q <= drive_sel_d;
      discard_q   <= discard_d;
      sectors_q   <= sectors_d;
      word_idx_q  <= word_idx_d;
      op_write_q  <= op_write_d;
      lba_q       <= lba_d;
      count_q     <= count_d;
    end
  end

endmodule

// ===== design/apls_queue.sv =====
module apls_queue
  import apls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic valid_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/apls_back.sv =====
module apls_back
  import apls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_pop_o,
  apls_out_if.source out_o
);

  logic [3:0]  step_q;
  logic        valid_q;
  kind_e       kind_q;
  logic [15:0] port_q, data_q, host_q;
  logic        last_q;

  kind_e       r_kind;
  logic [2:0]  r_ofs;
  logic        r_port_en;
  logic [15:0] r_data, r_host;
  logic        r_last;
  logic        load;
  logic [7:0]  sel_byte;

  assign load      = job_valid_i && (!valid_q || out_o.ready);
  assign job_pop_o = load && r_last;
  assign sel_byte  = DEV_SEL_LBA | (cfg_i.slave_select ? DEV_SEL_SLAVE : 8'h00);

  always_comb begin
    r_kind    = K_ERR;
    r_ofs     = OFS_DATA;
    r_port_en = 1'b0;
    r_data    = 16'd0;
    r_host    = 16'd0;
    r_last    = 1'b1;
    unique case (job_i.op)
      JOB_ERR: begin
        r_kind = K_ERR;
      end
      JOB_SELECT: begin
        r_port_en = 1'b1;
        if (step_q == 4'd0) begin
          r_kind = K_BUS_WR;
          r_ofs  = OFS_DRIVE;
          r_data = {8'h00, sel_byte};
          r_last = 1'b0;
        end else begin
          r_kind = K_BUS_RD;
          r_ofs  = OFS_CMD;
        end
      end
      JOB_POLL: begin
        r_kind    = K_BUS_RD;
        r_ofs     = OFS_CMD;
        r_port_en = 1'b1;
      end
      JOB_TASK: begin
        r_kind    = K_BUS_WR;
        r_port_en = 1'b1;
        r_last    = (step_q == TaskLastStep);
        unique case (step_q)
          4'd0: begin r_ofs = OFS_COUNT; r_data = {8'h00, job_i.count[15:8]}; end
          4'd1: begin r_ofs = OFS_LBA0;  r_data = {8'h00, job_i.lba[31:24]};  end
          4'd2: begin r_ofs = OFS_LBA1;  r_data = {8'h00, job_i.lba[39:32]};  end
          4'd3: begin r_ofs = OFS_LBA2;  r_data = {8'h00, job_i.lba[47:40]};  end
          4'd4: begin r_ofs = OFS_COUNT; r_data = {8'h00, job_i.count[7:0]};  end
          4'd5: begin r_ofs = OFS_LBA0;  r_data = {8'h00, job_i.lba[7:0]};    end
          4'd6: begin r_ofs = OFS_LBA1;  r_data = {8'h00, job_i.lba[15:8]};   end
          4'd7: begin r_ofs = OFS_LBA2;  r_data = {8'h00, job_i.lba[23:16]};  end
          4'd8: begin
            r_ofs  = OFS_CMD;
            r_data = {8'h00, job_i.op_write ? CMD_WRITE_EXT : CMD_READ_EXT};
          end
          default: begin
            r_kind = K_BUS_RD;
            r_ofs  = OFS_CMD;
          end
        endcase
      end
      JOB_NEED: begin
        r_kind = K_NEED;
      end
      JOB_RDDATA: begin
        r_kind    = K_BUS_RD;
        r_ofs     = OFS_DATA;
        r_port_en = 1'b1;
      end
      JOB_HOST, JOB_WDATA: begin
        if (step_q == 4'd0) begin
          r_last = 1'b0;
          if (job_i.op == JOB_HOST) begin
            r_kind = K_HOST;
            r_host = job_i.word;
          end else begin
            r_kind    = K_BUS_WR;
            r_ofs     = OFS_DATA;
            r_port_en = 1'b1;
            r_data    = job_i.word;
          end
        end else begin
          unique case (job_i.tail)
            TAIL_RDDATA: begin
              r_kind    = K_BUS_RD;
              r_ofs     = OFS_DATA;
              r_port_en = 1'b1;
            end
            TAIL_NEED: begin
              r_kind = K_NEED;
            end
            TAIL_POLL: begin
              r_kind    = K_BUS_RD;
              r_ofs     = OFS_CMD;
              r_port_en = 1'b1;
            end
            TAIL_FLUSH: begin
              if (step_q == 4'd1) begin
                r_kind    = K_BUS_WR;
                r_ofs     = OFS_CMD;
                r_port_en = 1'b1;
                r_data    = {8'h00, CMD_FLUSH_CACHE};
                r_last    = 1'b0;
              end else begin
                r_kind = K_DONE;
              end
            end
            default: begin
              r_kind = K_DONE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 4'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= r_last ? 4'd0 : step_q + 4'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= r_kind;
      port_q <= r_port_en ? (cfg_i.io_base + {13'd0, r_ofs}) : 16'd0;
      data_q <= r_data;
      host_q <= r_host;
      last_q <= r_last;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.kind      = kind_q;
  assign out_o.port      = port_q;
  assign out_o.bus_data  = data_q;
  assign out_o.host_word = host_q;
  assign out_o.last      = last_q;

endmodule

// ===== design/ata_pio_lba48_sequencer_top.sv =====
// Host-side ATA PIO sequencer for 48-bit LBA sector reads and writes.
// The in_i channel carries requests, answers to bus reads and write data
// words; the out_o channel returns bus writes, bus reads, host words, done,
// error and need-data results, with last set on the final result of each
// input transfer. Every bus read issued must be answered by a later input.
// The I/O base and slave_select are written over the APB port; the user must
// write them only while idle, which the block does not enforce. Any write
// forces the next request to select the drive again. A front stage
// classifies each input and updates the phase state in the cycle of its
// transfer, pushing a job into a two-entry queue. A back stage expands the
// head job into results, one per cycle while the receiver is ready, through
// an output register. Inputs are taken every cycle while the queue has room;
// a new request with the drive already selected expands into ten results, a
// select into two, a data word into up to three. When the receiver stalls,
// the output register holds and the queue fills, after which in_i.ready
// drops. Reset empties the queue and the output register and returns the
// control and configuration registers to their default values.
module ata_pio_lba48_sequencer_top
  import apls_pkg::*;
#(
  parameter int unsigned SelectStatusReads = SelectStatusReadsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  apls_in_if.sink     in_i,
  apls_out_if.source  out_o
);

  cfg_t cfg_q;
  logic cfg_wr;
  reg_e cfg_sel;
  job_t front_job, queue_job;
  logic front_valid, queue_full, queue_valid, back_pop;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_sel  = reg_e'(paddr_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.io_base      <= BasePortReset;
      cfg_q.slave_select <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_IO_BASE:      cfg_q.io_base      <= pwdata_i[15:0];
        REG_SLAVE_SELECT: cfg_q.slave_select <= pwdata_i[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_IO_BASE:      prdata_o = {16'd0, cfg_q.io_base};
      REG_SLAVE_SELECT: prdata_o = {31'd0, cfg_q.slave_select};
    endcase
  end

  apls_front #(
    .SelectStatusReads(SelectStatusReads)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .in_i       (in_i),
    .job_o      (front_job),
    .job_valid_o(front_valid),
    .job_ready_i(!queue_full)
  );

  apls_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_valid),
    .push_data_i(front_job),
    .full_o     (queue_full),
    .pop_i      (back_pop),
    .pop_data_o (queue_job),
    .valid_o    (queue_valid)
  );

  apls_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_i      (queue_job),
    .job_valid_i(queue_valid),
    .job_pop_o  (back_pop),
    .out_o      (out_o)
  );

endmodule

// ===== design/apls_checker.sv =====
module apls_checker
  import apls_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic [15:0] out_port_i,
  input logic [15:0] out_bus_data_i,
  input logic [15:0] out_host_word_i,
  input logic        out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_port_i) && $stable(out_bus_data_i) &&
    $stable(out_host_word_i) && $stable(out_last_i))
    else $error("Stalled output transfer changed.");

  a_final_kinds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == K_ERR || out_kind_i == K_DONE ||
    out_kind_i == K_NEED) |-> out_last_i)
    else $error("Error, done or need-data result without last.");

  a_host_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == K_HOST |-> !out_last_i && out_port_i == 16'd0 &&
    out_bus_data_i == 16'd0)
    else $error("Host word result is malformed.");

  a_read_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == K_BUS_RD |-> out_bus_data_i == 16'd0 &&
    out_host_word_i == 16'd0)
    else $error("Bus read result carries data.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("APB port inserted a wait state.");

endmodule

bind ata_pio_lba48_sequencer_top apls_checker u_apls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready_i       (pready_o),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_port_i     (out_o.port),
  .out_bus_data_i (out_o.bus_data),
  .out_host_word_i(out_o.host_word),
  .out_last_i     (out_o.last)
);

// ===== verif/tb_ata_pio_lba48_sequencer_top.sv =====
module tb_ata_pio_lba48_sequencer_top
  import apls_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned QuietCycles = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned MaxPrinted  = 40;

  localparam logic [7:0] StatusBusy = STATUS_RDY_MASK & ~STATUS_RDY_VAL;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DISCARD,
    PH_POLL,
    PH_RDATA,
    PH_WDATA
  } seq_phase_e;

  typedef enum int unsigned {
    ST_BUSY,
    ST_NOT_READY,
    ST_READY,
    ST_FAULT
  } status_pick_e;

  typedef struct packed {
    func_e       func;
    logic        is_write;
    logic [47:0] lba;
    logic [15:0] count;
    logic [15:0] rd;
    logic [15:0] wr;
  } host_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] port;
    logic [15:0] bus_data;
    logic [15:0] host_word;
    logic        last;
  } bus_result_t;

  typedef struct {
    seq_phase_e  phase;
    logic        sel_done;
    logic [2:0]  discard_left;
    logic [15:0] sectors_left;
    logic [7:0]  word_idx;
    logic        op_write;
    logic [47:0] lba;
    logic [15:0] count;
    logic [15:0] base;
    logic        slave;
  } seq_state_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  apls_in_if  in_if ();
  apls_out_if out_if ();

  host_item_t  in_backlog[$];
  bus_result_t expected_q[$];
  seq_state_t  pred_st;
  seq_state_t  plan_st;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned fails = 0;
  int unsigned planned_items = 0;
  int unsigned hold_left = 0;
  bit          hold_tog = 1'b0;
  bit          hold_seen = 1'b0;
  logic        in_taken = 1'b0;

  ata_pio_lba48_sequencer_top dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic seq_state_t reset_state();
    seq_state_t st;
    st.phase        = PH_IDLE;
    st.sel_done     = 1'b0;
    st.discard_left = '0;
    st.sectors_left = '0;
    st.word_idx     = '0;
    st.op_write     = 1'b0;
    st.lba          = '0;
    st.count        = '0;
    st.base         = BasePortReset;
    st.slave        = 1'b0;
    return st;
  endfunction

  function automatic bus_result_t mk_res(kind_e k, logic [15:0] p, logic [15:0] d,
                                         logic [15:0] h);
    bus_result_t r;
    r.kind      = k;
    r.port      = p;
    r.bus_data  = d;
    r.host_word = h;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] port_at(seq_state_t st, logic [2:0] ofs);
    return st.base + 16'(ofs);
  endfunction

  function automatic void add_poll(inout seq_state_t st, inout bus_result_t res[$]);
    st.phase = PH_POLL;
    res.push_back(mk_res(K_BUS_RD, port_at(st, OFS_CMD), '0, '0));
  endfunction

  function automatic void add_taskfile(inout seq_state_t st, inout bus_result_t res[$]);
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_COUNT), {8'h00, st.count[15:8]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_LBA0), {8'h00, st.lba[31:24]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_LBA1), {8'h00, st.lba[39:32]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_LBA2), {8'h00, st.lba[47:40]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_COUNT), {8'h00, st.count[7:0]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_LBA0), {8'h00, st.lba[7:0]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_LBA1), {8'h00, st.lba[15:8]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_LBA2), {8'h00, st.lba[23:16]}, '0));
    res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_CMD),
                         {8'h00, st.op_write ? CMD_WRITE_EXT : CMD_READ_EXT}, '0));
    add_poll(st, res);
  endfunction

  function automatic void add_sector_end(inout seq_state_t st, inout bus_result_t res[$]);
    st.word_idx     = '0;
    st.sectors_left = st.sectors_left - 16'd1;
    if (st.sectors_left != '0) begin
      add_poll(st, res);
    end else begin
      if (st.op_write) begin
        res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_CMD), {8'h00, CMD_FLUSH_CACHE}, '0));
      end
      st.phase = PH_IDLE;
      res.push_back(mk_res(K_DONE, '0, '0, '0));
    end
  endfunction

  function automatic void sequence_step(inout seq_state_t st, input host_item_t it,
                                        output bus_result_t res[$]);
    logic [7:0] s;
    res = {};
    s   = it.rd[7:0];
    case (it.func)
      FUNC_REQ: begin
        if (st.phase != PH_IDLE || it.count == '0) begin
          res.push_back(mk_res(K_ERR, '0, '0, '0));
        end else begin
          st.op_write     = it.is_write;
          st.lba          = it.lba;
          st.count        = it.count;
          st.sectors_left = it.count;
          st.word_idx     = '0;
          if (!st.sel_done) begin
            res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_DRIVE),
                                 {8'h00, DEV_SEL_LBA | (st.slave ? DEV_SEL_SLAVE : 8'h00)},
                                 '0));
            res.push_back(mk_res(K_BUS_RD, port_at(st, OFS_CMD), '0, '0));
            st.discard_left = 3'(SelectStatusReadsDefault);
            st.phase        = PH_DISCARD;
          end else begin
            add_taskfile(st, res);
          end
        end
      end
      FUNC_RD_ANS: begin
        case (st.phase)
          PH_DISCARD: begin
            st.discard_left = st.discard_left - 3'd1;
            if (st.discard_left != '0) begin
              res.push_back(mk_res(K_BUS_RD, port_at(st, OFS_CMD), '0, '0));
            end else begin
              st.sel_done = 1'b1;
              add_taskfile(st, res);
            end
          end
          PH_POLL: begin
            if ((s & STATUS_ERR_MASK) != '0) begin
              st.phase        = PH_IDLE;
              st.sectors_left = '0;
              st.word_idx     = '0;
              res.push_back(mk_res(K_ERR, '0, '0, '0));
            end else if ((s & STATUS_RDY_MASK) != STATUS_RDY_VAL) begin
              add_poll(st, res);
            end else begin
              st.word_idx = '0;
              if (st.op_write) begin
                st.phase = PH_WDATA;
                res.push_back(mk_res(K_NEED, '0, '0, '0));
              end else begin
                st.phase = PH_RDATA;
                res.push_back(mk_res(K_BUS_RD, port_at(st, OFS_DATA), '0, '0));
              end
            end
          end
          PH_RDATA: begin
            res.push_back(mk_res(K_HOST, '0, '0, it.rd));
            if (st.word_idx >= LastWordIndex) begin
              add_sector_end(st, res);
            end else begin
              st.word_idx = st.word_idx + 8'd1;
              res.push_back(mk_res(K_BUS_RD, port_at(st, OFS_DATA), '0, '0));
            end
          end
          default: ;
        endcase
      end
      FUNC_WR_WORD: begin
        if (st.phase == PH_WDATA) begin
          res.push_back(mk_res(K_BUS_WR, port_at(st, OFS_DATA), it.wr, '0));
          if (st.word_idx >= LastWordIndex) begin
            add_sector_end(st, res);
          end else begin
            st.word_idx = st.word_idx + 8'd1;
            res.push_back(mk_res(K_NEED, '0, '0, '0));
          end
        end
      end
      default: ;
    endcase
    if (res.size() != 0) begin
      res[res.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void cfg_apply(inout seq_state_t st, input reg_e r, input logic [31:0] v);
    if (r == REG_IO_BASE) begin
      st.base = v[15:0];
    end else begin
      st.slave = v[0];
    end
    st.sel_done = 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    if (fails < MaxPrinted) begin
      $display("MISMATCH: %s", msg);
    end
    fails++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    host_item_t  it;
    bus_result_t got;
    bus_result_t want;
    bus_result_t fresh[$];
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        it.func     = func_e'(in_if.func);
        it.is_write = in_if.is_write;
        it.lba      = in_if.lba;
        it.count    = in_if.sector_count;
        it.rd       = in_if.bus_read_data;
        it.wr       = in_if.write_word;
        sequence_step(pred_st, it, fresh);
        foreach (fresh[i]) begin
          expected_q.push_back(fresh[i]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        got.kind      = kind_e'(out_if.kind);
        got.port      = out_if.port;
        got.bus_data  = out_if.bus_data;
        got.host_word = out_if.host_word;
        got.last      = out_if.last;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d port %h", got.kind, got.port));
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 16'(got.kind), 16'(want.kind));
          check_field("port", got.port, want.port);
          check_field("bus_data", got.bus_data, want.bus_data);
          check_field("host_word", got.host_word, want.host_word);
          check_field("last", 16'(got.last), 16'(want.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    host_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (in_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = in_backlog.pop_front();
        in_if.func          <= nxt.func;
        in_if.is_write      <= nxt.is_write;
        in_if.lba           <= nxt.lba;
        in_if.sector_count  <= nxt.count;
        in_if.bus_read_data <= nxt.rd;
        in_if.write_word    <= nxt.wr;
        in_if.valid         <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_tog != hold_seen) begin
      hold_seen    <= hold_tog;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic host_item_t mk_item(func_e f, logic w, logic [47:0] a, logic [15:0] c,
                                         logic [15:0] r, logic [15:0] d);
    host_item_t it;
    it.func     = f;
    it.is_write = w;
    it.lba      = a;
    it.count    = c;
    it.rd       = r;
    it.wr       = d;
    return it;
  endfunction

  function automatic host_item_t rand_item(func_e f);
    return mk_item(f, 1'($urandom), {16'($urandom), 32'($urandom)}, 16'($urandom),
                   16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [7:0] status_byte(status_pick_e pick);
    logic [7:0] s;
    s = 8'($urandom);
    case (pick)
      ST_BUSY:      s = (s & ~STATUS_ERR_MASK) | StatusBusy;
      ST_NOT_READY: s = s & ~(STATUS_ERR_MASK | STATUS_RDY_MASK);
      ST_READY:     s = (s & ~(STATUS_ERR_MASK | StatusBusy)) | STATUS_RDY_VAL;
      default: begin
        if ((s & STATUS_ERR_MASK) == '0) begin
          s = s | (($urandom_range(1) != 0) ? (STATUS_ERR_MASK & 8'h01) :
                                               (STATUS_ERR_MASK & 8'h20));
        end
      end
    endcase
    return s;
  endfunction

  task automatic queue_item(host_item_t it);
    bus_result_t planned[$];
    sequence_step(plan_st, it, planned);
    in_backlog.push_back(it);
    if (planned.size() != 0) begin
      planned_items++;
    end
  endtask

  task automatic queue_status(status_pick_e pick);
    host_item_t it;
    it         = rand_item(FUNC_RD_ANS);
    it.rd[7:0] = status_byte(pick);
    queue_item(it);
  endtask

  task automatic run_request(logic wr, logic [47:0] a, logic [15:0] c, bit complete);
    int unsigned pick;
    host_item_t  it;
    it          = rand_item(FUNC_REQ);
    it.is_write = wr;
    it.lba      = a;
    it.count    = c;
    queue_item(it);
    while (plan_st.phase != PH_IDLE) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        case ($urandom_range(2))
          0:       queue_item(rand_item(FUNC_REQ));
          1:       queue_item(rand_item(FUNC_NONE));
          default: queue_item(rand_item(plan_st.phase == PH_WDATA ? FUNC_RD_ANS : FUNC_WR_WORD));
        endcase
      end else begin
        case (plan_st.phase)
          PH_POLL: begin
            if (complete) begin
              queue_status(pick < 20 ? ST_BUSY : pick < 30 ? ST_NOT_READY : ST_READY);
            end else begin
              queue_status(pick < 30 ? ST_BUSY : pick < 45 ? ST_NOT_READY : ST_FAULT);
            end
          end
          PH_WDATA: queue_item(rand_item(FUNC_WR_WORD));
          default:  queue_item(rand_item(FUNC_RD_ANS));
        endcase
      end
    end
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    host_item_t  it;
    stop = planned_items + budget;
    while (planned_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_item(rand_item(func_e'($urandom_range(3, 1))));
      end else if (pick < 16) begin
        it       = rand_item(FUNC_REQ);
        it.count = '0;
        queue_item(it);
      end else begin
        run_request(1'($urandom), {16'($urandom), 32'($urandom)},
                    16'($urandom_range(65535, 1)), 1'b0);
      end
    end
  endtask

  task automatic wait_quiet();
    while (in_backlog.size() != 0 || in_if.valid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic cfg_write_verify(reg_e r, logic [31:0] v);
    logic [31:0] want;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cfg_apply(pred_st, r, v);
    cfg_apply(plan_st, r, v);
    want = (r == REG_IO_BASE) ? {16'h0000, pred_st.base} : {31'h0, pred_st.slave};
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %0d read %h expected %h", r, prdata, want));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.func          = FUNC_NONE;
    in_if.is_write      = 1'b0;
    in_if.lba           = '0;
    in_if.sector_count  = '0;
    in_if.bus_read_data = '0;
    in_if.write_word    = '0;
    out_if.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pred_st             = reset_state();
    plan_st             = reset_state();
    send_idle           = 33;
    recv_idle           = 57;
    rst_n               = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, 16'hFFFF, '0));
    queue_item(mk_item(FUNC_WR_WORD, 1'b1, '1, '1, '0, 16'hFFFF));
    queue_item(mk_item(FUNC_NONE, 1'b1, '1, '1, '1, '1));
    queue_item(mk_item(FUNC_REQ, 1'b1, '1, '0, '0, '0));
    queue_item(mk_item(FUNC_REQ, 1'b0, '1, '1, '0, '0));
    for (int i = 0; i < SelectStatusReadsDefault; i++) begin
      queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, (i % 2 != 0) ? 16'hFFFF : 16'h0000, '0));
    end
    queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, 16'h0080, '0));
    queue_item(mk_item(FUNC_REQ, 1'b1, '0, 16'h0001, '0, '0));
    queue_item(mk_item(FUNC_WR_WORD, 1'b0, '0, '0, '0, 16'h5AA5));
    queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, 16'hFF09, '0));
    queue_item(mk_item(FUNC_REQ, 1'b1, '0, 16'h0001, '0, '0));
    queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, 16'h0000, '0));
    queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, 16'h00FF, '0));
    queue_item(mk_item(FUNC_REQ, 1'b1, 48'h1234_5678_9ABC, 16'h0100, '0, '0));
    queue_item(mk_item(FUNC_RD_ANS, 1'b0, '0, '0, 16'h0028, '0));
    wait_quiet();

    cfg_write_verify(REG_IO_BASE, 32'h0000_FFFF);
    cfg_write_verify(REG_SLAVE_SELECT, 32'h0000_0001);
    run_request(1'b0, {16'($urandom), 32'($urandom)}, 16'd1, 1'b1);
    random_phase(10);
    wait_quiet();

    send_idle = 57;
    recv_idle = 33;
    cfg_write_verify(REG_IO_BASE, 32'h0000_0000);
    cfg_write_verify(REG_SLAVE_SELECT, 32'h0000_0000);
    random_phase(10);
    wait_quiet();

    send_idle = 0;
    recv_idle = 0;
    cfg_write_verify(REG_IO_BASE, 32'($urandom));
    cfg_write_verify(REG_SLAVE_SELECT, 32'($urandom));
    run_request(1'b1, {16'($urandom), 32'($urandom)}, 16'd1, 1'b1);
    hold_tog = ~hold_tog;
    random_phase(10);
    wait_quiet();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
